// ===== sv/dhf_pkg.sv =====
`timescale 1ns / 1ps
// Package for the double-to-half converter: field widths and format constants.
// No dependencies.
package dhf_pkg;
   localparam int unsigned DblWidth   = 64;
   localparam int unsigned HalfWidth  = 16;
   localparam int unsigned FracBits   = 52;
   localparam logic [10:0] DblExpMax  = 11'h7FF;
   localparam logic [10:0] DblBias    = 11'd1023;
   localparam logic [15:0] HalfInf    = 16'h7C00;
   localparam logic [15:0] HalfNan    = 16'h7FFF;
   // biased double exponents of the range edges
   localparam logic [10:0] OvfExp     = 11'd1039;   // 2^16
   localparam logic [10:0] MinNormExp = 11'd1009;   // 2^-14
   localparam int unsigned SmallScale = 25;
endpackage

// ===== sv/double_to_half_float_convert.sv =====
`timescale 1ns / 1ps
// Top level of the double-to-half converter: three-stage pipeline.
// Depends on dhf_pkg.
//
// Takes one binary64 pattern per beat and returns the truncated half pattern
// from the last stage. One beat can enter every cycle while req_stall is low; the
// three-stage pipeline holds in place under rsp_stall while req_stall
// follows the last stage, so no beat is dropped or repeated.
module double_to_half_float_convert (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_double_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_half_bits
);
   // case codes decided in stage 1
   localparam logic [2:0] KZero = 3'd0, KNan = 3'd1, KInf = 3'd2,
                          KNorm = 3'd3, KSmall = 3'd4;

   logic        v1_ff, v2_ff, v3_ff;
   logic        adv;
   logic        s1_ff, s2_ff;
   logic [2:0]  k1_ff, k2_ff;
   logic [10:0] e1_ff, e2_ff;
   logic [52:0] sig1_ff;
   logic [9:0]  m2_ff;
   logic [15:0] h3_ff;
   logic [2:0]  k1_in;
   logic [10:0] eb;
   logic [51:0] fr;
   logic [9:0]  m2_in;
   logic [15:0] h3_in;
   logic [10:0] sh;

   // whole pipe advances together unless the output beat is held
   assign adv       = !(v3_ff && rsp_stall);
   assign req_stall = !adv;

   // stage 1: classify
   assign eb = req_double_bits[62:52];
   assign fr = req_double_bits[51:0];
   always_comb begin
      if (eb == dhf_pkg::DblExpMax) k1_in = (fr != '0) ? KNan : KInf;
      else if (eb == '0) k1_in = KZero;
      else if (eb >= dhf_pkg::OvfExp) k1_in = KInf;
      else if (eb >= dhf_pkg::MinNormExp) k1_in = KNorm;
      else k1_in = KSmall;
   end

   // stage 2: mantissa shift for small values, shift = 52-25-(eb-1023)
   assign sh = 11'd1050 - e1_ff;
   always_comb begin
      if (k1_ff == KSmall) begin
         if (sh >= 11'd64) m2_in = '0;
         else m2_in = 10'((sig1_ff >> sh[5:0]));
      end else begin
         m2_in = sig1_ff[51:42];
      end
   end

   // stage 3: pack
   always_comb begin
      case (k2_ff)
         KNan:   h3_in = dhf_pkg::HalfNan;
         KInf:   h3_in = {s2_ff, 15'd0} | dhf_pkg::HalfInf;
         KNorm:  h3_in = {s2_ff, 5'(e2_ff - 11'd1008), m2_ff};
         KSmall: h3_in = {s2_ff, 5'd0, m2_ff};
         // double zero or subnormal: sign only when nonzero subnormal
         default: h3_in = {s2_ff & (e2_ff == '0) & 1'b0, 15'd0} |
                          (e2_ff == 11'd1 ? {s2_ff, 15'd0} : 16'd0);
      endcase
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid; v2_ff <= v1_ff; v3_ff <= v2_ff;
      end
   end

   // advance payload; e1 carries 1 to flag a nonzero double subnormal
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff   <= req_double_bits[63];
         k1_ff   <= k1_in;
         e1_ff   <= (eb == '0) ? {10'd0, fr != '0} : eb;
         sig1_ff <= {1'b1, fr};
         s2_ff   <= s1_ff; k2_ff <= k1_ff; e2_ff <= e1_ff; m2_ff <= m2_in;
         h3_ff   <= h3_in;
      end
   end

   assign rsp_valid     = v3_ff;
   assign rsp_half_bits = h3_ff;

   // a held result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_half_bits))
      else $error("held result changed");
   // NaN never carries a sign
   a_nan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_half_bits[14:10] == 5'h1F && rsp_half_bits[9:0] != '0
      |-> rsp_half_bits == dhf_pkg::HalfNan)
      else $error("bad NaN");
   // input stall only when output is held
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("spurious stall");
endmodule

// ===== dv/tb_double_to_half_float_convert.sv =====
`timescale 1ns / 1ps
// Testbench for the double-to-half converter: random and directed binary64 beats,
// results checked against an in-bench truncating converter. Depends on dhf_pkg and the RTL.
module tb_double_to_half_float_convert;

   // Scoreboard: converts accepted doubles and checks halves in order
   class half_scoreboard;
      logic [15:0] pending_halves[$];
      int unsigned errors;
      int unsigned checked;

      function logic [15:0] to_half(logic [63:0] d);
         logic        sgn;
         logic [10:0] e;
         logic [51:0] f;
         logic [52:0] sig;
         int          sh;
         sgn = d[63];
         e   = d[62:52];
         f   = d[51:0];
         if (e == dhf_pkg::DblExpMax) begin
            if (f != '0) return dhf_pkg::HalfNan;
            return {sgn, 15'b0} | dhf_pkg::HalfInf;
         end
         if (e == '0) begin
            if (f == '0) return 16'h0000;
            return {sgn, 15'b0};
         end
         if (e >= dhf_pkg::OvfExp) return {sgn, 15'b0} | dhf_pkg::HalfInf;
         if (e >= dhf_pkg::MinNormExp)
            return {sgn, 5'(e - dhf_pkg::MinNormExp + 11'd1), f[51:42]};
         // small magnitude: floor(|v| * 2^25), low ten bits kept
         sig = {1'b1, f};
         sh  = int'(dhf_pkg::FracBits) - int'(dhf_pkg::SmallScale)
               - (int'(e) - int'(dhf_pkg::DblBias));
         if (sh >= 64) return {sgn, 15'b0};
         return {sgn, 5'b0, 10'(sig >> sh)};
      endfunction

      function void note_double(logic [63:0] d);
         pending_halves.push_back(to_half(d));
      endfunction

      function void check_half(logic [15:0] h);
         logic [15:0] want;
         if (pending_halves.size() == 0) begin
            $display("%0t: unexpected half beat, expected none, actual %h", $time, h);
            errors++;
            return;
         end
         want = pending_halves.pop_front();
         checked++;
         if (want !== h) begin
            $display("%0t: half_bits mismatch, expected %h, actual %h", $time, want, h);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_double_bits = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_half_bits;
   bit          quiet = 1'b0;
   half_scoreboard board = new();

   double_to_half_float_convert DUT (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Sample both channels at the edge; stall bursts on the result side
   int unsigned stall_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_double(req_double_bits);
         if (rsp_valid && !rsp_stall) board.check_half(rsp_half_bits);
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
         end else if (!quiet && $urandom_range(0, 15) == 0) begin
            stall_left <= $urandom_range(0, 17);
            rsp_stall  <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Send one beat, optionally after an idle burst; hold until accepted
   task automatic send_double(logic [63:0] d);
      int unsigned gap;
      if (!quiet && $urandom_range(0, 15) == 0) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_double_bits <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic [63:0] make_double(logic s, logic [10:0] e, logic [51:0] f);
      return {s, e, f};
   endfunction

   function automatic logic [63:0] rand_double();
      logic [63:0] d;
      logic [10:0] e;
      d = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       e = 11'd0;
         1:       e = dhf_pkg::DblExpMax;
         2:       e = 11'($urandom_range(1, 2046));
         3, 4:    e = 11'($urandom_range(int'(dhf_pkg::MinNormExp) - 48,
                                         int'(dhf_pkg::MinNormExp) - 1));
         default: e = 11'($urandom_range(int'(dhf_pkg::MinNormExp) - 2,
                                         int'(dhf_pkg::OvfExp) + 2));
      endcase
      if ($urandom_range(0, 19) == 0) d[51:0] = '0;
      d[62:52] = e;
      return d;
   endfunction

   initial begin
      #5ms;
      $display("double_to_half_float_convert test failed");
      $finish;
   end

   initial begin
      int n;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: zeros, infinities, NaNs, range edges, small scale, subnormals
      send_double(64'h0);
      send_double(64'h8000_0000_0000_0000);
      send_double(make_double(1'b0, dhf_pkg::DblExpMax, '0));
      send_double(make_double(1'b1, dhf_pkg::DblExpMax, '0));
      send_double(make_double(1'b0, dhf_pkg::DblExpMax, 52'h1));
      send_double(make_double(1'b1, dhf_pkg::DblExpMax, '1));
      send_double(make_double(1'b0, dhf_pkg::OvfExp, '0));
      send_double(make_double(1'b1, 11'(dhf_pkg::OvfExp - 11'd1), '1));
      send_double(make_double(1'b0, dhf_pkg::MinNormExp, '0));
      send_double(make_double(1'b1, dhf_pkg::MinNormExp, '1));
      send_double(make_double(1'b0, 11'(dhf_pkg::MinNormExp - 11'd1), '1));
      send_double(make_double(1'b1, 11'(dhf_pkg::MinNormExp - 11'd1), '0));
      send_double(make_double(1'b0, 11'(dhf_pkg::MinNormExp - 11'd10), 52'h5_5555_5555_5555));
      send_double(make_double(1'b0, 11'(dhf_pkg::MinNormExp - 11'd11), '1));
      send_double(make_double(1'b1, 11'(dhf_pkg::MinNormExp - 11'd40), '1));
      send_double(make_double(1'b0, 11'd0, 52'h1));
      send_double(make_double(1'b1, 11'd0, '1));
      send_double(64'hFFFF_FFFF_FFFF_FFFF);
      send_double(make_double(1'b0, 11'd1, '0));
      send_double(make_double(1'b0, 11'd2046, '1));
      for (n = 0; n < 2000; n++) begin
         if (n == 1800) quiet = 1'b1;
         send_double(rand_double());
      end
      req_valid <= 1'b0;
      while (board.pending_halves.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Converted %0d doubles: zeros, NaNs, infinities, overflow,", board.checked);
      $display("normal and small range, under random idling and result stalls.");
      if (board.errors == 0) begin
         $display("double_to_half_float_convert test passed");
      end else begin
         $display("double_to_half_float_convert test failed");
      end
      $finish;
   end
endmodule
